// ----- design/ncs_pkg.sv -----
// shared constants, types and helpers for the nearest centroid search block
`default_nettype none

package ncs_pkg;

  // sizing of the stored centroid table and point buffer
  localparam int MAX_CENTROIDS = 64;
  localparam int MAX_DIMS      = 64;
  localparam int COORD_BITS    = 16;

  // field widths
  localparam int IDX_W     = 6;
  localparam int CFG_W     = 7;
  localparam int DIST_W    = 38;
  localparam int REG_IDX_W = 8;

  // derived datapath widths
  localparam int DIFF_W  = COORD_BITS + 1;
  localparam int SQ_W    = 2 * DIFF_W;
  localparam int CADDR_W = $clog2(MAX_CENTROIDS * MAX_DIMS);
  localparam int DADDR_W = $clog2(MAX_DIMS);
  localparam int CSEL_W  = $clog2(MAX_CENTROIDS);

  // register indexes
  localparam logic [REG_IDX_W-1:0] REG_CLUSTERS = REG_IDX_W'(0);
  localparam logic [REG_IDX_W-1:0] REG_DIMS     = REG_IDX_W'(1);

  // item actions
  localparam logic ACT_LOAD  = 1'b0;
  localparam logic ACT_POINT = 1'b1;

  // controller to datapath
  typedef struct packed {
    logic accept_en;  // input channel may take a word
    logic start;      // clear the walk counters
    logic issue;      // read one centroid/point coordinate pair
    logic out_load;   // move the winner into the output register
  } ncs_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic point_done;  // accepted word completes a point
    logic issue_last;  // counters sit on the last pair of the walk
    logic pipe_busy;   // pairs still in flight
    logic out_free;    // output register can take a result
  } ncs_stat_t;

  // zero acts as one, anything above the maximum saturates
  function automatic logic [CFG_W-1:0] clamp_reg(input logic [CFG_W-1:0] v, input int maxv);
    logic [CFG_W-1:0] r;
    begin
      if (v == '0) begin
        r = CFG_W'(1);
      end else if (int'(v) > maxv) begin
        r = CFG_W'(maxv);
      end else begin
        r = v;
      end
      return r;
    end
  endfunction

endpackage

`default_nettype wire

// ----- design/ncs_ifs.sv -----
// channel interfaces: input words, result words and register writes
`default_nettype none

interface ncs_item_if import ncs_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic                   action;
  logic [IDX_W-1:0]       centroid_index;
  logic [IDX_W-1:0]       dim_index;
  logic signed [COORD_BITS-1:0] coord_value;

  modport source (output valid, action, centroid_index, dim_index, coord_value,
                  input ready);
  modport sink   (input valid, action, centroid_index, dim_index, coord_value,
                  output ready);
endinterface

interface ncs_result_if import ncs_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [IDX_W-1:0]  nearest_index;
  logic [DIST_W-1:0] squared_distance;

  modport source (output valid, nearest_index, squared_distance, input ready);
  modport sink   (input valid, nearest_index, squared_distance, output ready);
endinterface

interface ncs_cfg_if import ncs_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [REG_IDX_W-1:0] index;
  logic [CFG_W-1:0]     data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ----- design/ncs_ctrl.sv -----
// controller state machine: idle, centroid walk, pipeline drain
`default_nettype none

module ncs_ctrl import ncs_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire ncs_stat_t stat,
  output ncs_cmd_t       cmd
);

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_SEARCH = 2'd1;
  localparam logic [1:0] S_DRAIN  = 2'd2;

  logic [1:0] state;
  logic [1:0] state_next;

  always_comb begin
    state_next    = state;
    cmd.accept_en = 1'b0;
    cmd.start     = 1'b0;
    cmd.issue     = 1'b0;
    cmd.out_load  = 1'b0;
    unique case (state)
      S_IDLE: begin
        cmd.accept_en = 1'b1;
        if (stat.point_done) begin
          cmd.start  = 1'b1;
          state_next = S_SEARCH;
        end
      end
      S_SEARCH: begin
        cmd.issue = 1'b1;
        if (stat.issue_last) begin
          state_next = S_DRAIN;
        end
      end
      S_DRAIN: begin
        if (!stat.pipe_busy && stat.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

`default_nettype wire

// ----- design/ncs_dp.sv -----
// datapath: registers, centroid table, point buffer, distance pipeline, output word
`default_nettype none

module ncs_dp import ncs_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst,
  ncs_item_if.sink      items,
  ncs_result_if.source  results,
  ncs_cfg_if.sink       cfg,
  input  wire ncs_cmd_t cmd,
  output ncs_stat_t     stat
);

  // configuration
  logic [CFG_W-1:0] clusters;
  logic [CFG_W-1:0] dims;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      clusters <= CFG_W'(1);
      dims     <= CFG_W'(1);
    end else if (cfg.valid) begin
      if (cfg.index == REG_CLUSTERS) begin
        clusters <= clamp_reg(cfg.data, MAX_CENTROIDS);
      end else if (cfg.index == REG_DIMS) begin
        dims <= clamp_reg(cfg.data, MAX_DIMS);
      end
    end
  end

  logic [CFG_W-1:0] dims_m1;
  logic [CFG_W-1:0] clusters_m1;
  assign dims_m1     = dims - CFG_W'(1);
  assign clusters_m1 = clusters - CFG_W'(1);

  // input word decode
  logic accept;
  logic dim_ok;
  logic cent_wr;
  logic pt_wr;

  assign items.ready = cmd.accept_en;
  assign accept      = items.valid && cmd.accept_en;
  assign dim_ok      = CFG_W'(items.dim_index) < dims;
  assign cent_wr     = accept && dim_ok && (items.action == ACT_LOAD)
                       && (CFG_W'(items.centroid_index) < clusters);
  assign pt_wr       = accept && dim_ok && (items.action == ACT_POINT);

  assign stat.point_done = pt_wr && (CFG_W'(items.dim_index) == dims_m1);

  // walk counters
  logic [CSEL_W-1:0]  cnt_c;
  logic [DADDR_W-1:0] cnt_d;
  logic               d_last;

  assign d_last          = CFG_W'(cnt_d) == dims_m1;
  assign stat.issue_last = d_last && (CFG_W'(cnt_c) == clusters_m1);

  always_ff @(posedge clk) begin
    if (rst || cmd.start) begin
      cnt_c <= '0;
      cnt_d <= '0;
    end else if (cmd.issue) begin
      if (d_last) begin
        cnt_d <= '0;
        cnt_c <= cnt_c + CSEL_W'(1);
      end else begin
        cnt_d <= cnt_d + DADDR_W'(1);
      end
    end
  end

  // memories with registered reads
  logic signed [COORD_BITS-1:0] cent_mem [MAX_CENTROIDS*MAX_DIMS];
  logic signed [COORD_BITS-1:0] pt_mem [MAX_DIMS];
  logic signed [COORD_BITS-1:0] cent_q;
  logic signed [COORD_BITS-1:0] pt_q;
  logic [CADDR_W-1:0]           cent_waddr;
  logic [CADDR_W-1:0]           cent_raddr;

  assign cent_waddr = CADDR_W'(int'(items.centroid_index) * MAX_DIMS + int'(items.dim_index));
  assign cent_raddr = CADDR_W'(int'(cnt_c) * MAX_DIMS + int'(cnt_d));

  always_ff @(posedge clk) begin
    if (cent_wr) begin
      cent_mem[cent_waddr] <= items.coord_value;
    end
    cent_q <= cent_mem[cent_raddr];
  end

  always_ff @(posedge clk) begin
    if (pt_wr) begin
      pt_mem[DADDR_W'(items.dim_index)] <= items.coord_value;
    end
    pt_q <= pt_mem[cnt_d];
  end

  // pipeline tags: 1 read, 2 difference, 3 square, 4 running sum
  logic              s1_valid, s2_valid, s3_valid, s4_valid;
  logic              s1_first, s2_first, s3_first;
  logic              s1_last, s2_last, s3_last, s4_last;
  logic [CSEL_W-1:0] s1_c, s2_c, s3_c, s4_c;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      s3_valid <= 1'b0;
      s4_valid <= 1'b0;
    end else begin
      s1_valid <= cmd.issue;
      s2_valid <= s1_valid;
      s3_valid <= s2_valid;
      s4_valid <= s3_valid;
    end
  end

  always_ff @(posedge clk) begin
    s1_first <= cnt_d == '0;
    s1_last  <= d_last;
    s1_c     <= cnt_c;
    s2_first <= s1_first;
    s2_last  <= s1_last;
    s2_c     <= s1_c;
    s3_first <= s2_first;
    s3_last  <= s2_last;
    s3_c     <= s2_c;
    s4_last  <= s3_last;
    s4_c     <= s3_c;
  end

  assign stat.pipe_busy = s1_valid || s2_valid || s3_valid || s4_valid;

  // arithmetic stages
  logic signed [DIFF_W-1:0] diff;
  logic signed [SQ_W-1:0]   sq_full;
  logic [SQ_W-1:0]          sq;
  logic [DIST_W:0]          sum_w;
  logic [DIST_W-1:0]        acc;

  assign sq_full = diff * diff;
  assign sum_w   = {1'b0, acc} + (DIST_W+1)'(sq);

  always_ff @(posedge clk) begin
    diff <= DIFF_W'(pt_q) - DIFF_W'(cent_q);
    sq   <= sq_full;
    if (s3_valid) begin
      if (s3_first) begin
        acc <= DIST_W'(sq);
      end else if (sum_w[DIST_W]) begin
        acc <= '1;
      end else begin
        acc <= sum_w[DIST_W-1:0];
      end
    end
  end

  // best so far, strict compare keeps the lowest index on ties
  logic [DIST_W-1:0] best;
  logic [CSEL_W-1:0] best_idx;

  always_ff @(posedge clk) begin
    if (s4_valid && s4_last && ((s4_c == '0) || (acc < best))) begin
      best     <= acc;
      best_idx <= s4_c;
    end
  end

  // output register
  logic out_valid;

  assign stat.out_free = !out_valid || results.ready;
  assign results.valid = out_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (results.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      results.nearest_index    <= IDX_W'(best_idx);
      results.squared_distance <= best;
    end
  end

  // the winner only leaves once every pair has been summed
  a_load_after_drain: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> !stat.pipe_busy)
    else $error("result loaded with pairs in flight");

  // after a centroid is finished the best distance is no larger than its sum
  a_best_not_worse: assert property (@(posedge clk) disable iff (rst)
    (s4_valid && s4_last) |=> (best <= $past(acc)))
    else $error("best distance larger than a finished centroid");

  // the centroid table and point buffer are stable while the walk reads them
  a_no_write_in_walk: assert property (@(posedge clk) disable iff (rst)
    (cmd.issue || stat.pipe_busy) |-> !(cent_wr || pt_wr))
    else $error("table written during a search");

  // the winner is one of the centroids in use
  a_idx_in_use: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> (CFG_W'(best_idx) < clusters))
    else $error("winner index outside the centroids in use");

endmodule

`default_nettype wire

// ----- design/nearest_centroid_search_top.sv -----
// top level of the nearest centroid search block
//
// vector quantizer: load words (action 0) write one coordinate of one
// centroid into a 64 x 64 table; point words (action 1) write one point
// coordinate into a 64 entry buffer, and the word for dimension
// dims_in_use-1 starts a walk over centroids 0 .. clusters_in_use-1 that
// returns the lowest-indexed closest centroid and its squared euclidean
// distance (saturating at 2^38-1). load words with a centroid or dimension
// index, and point words with a dimension index, at or beyond the configured
// counts are dropped without a result. a search runs through the single
// shared subtract / square / accumulate pipeline that reads one table entry
// per cycle. the input channel takes no word during the walk, while a
// finished result can still sit in the output register waiting for the sink.
// registers (0 clusters_in_use, 1 dims_in_use, reset 1, 0 read as 1, larger
// values saturate at 64) are to be written by the user only while the block
// is idle; the block itself does not enforce it. the tables are not cleared
// by reset, so every centroid and point coordinate in use must be written
// before a search.
`default_nettype none

module nearest_centroid_search_top import ncs_pkg::*; (
  input  wire logic    clk,
  input  wire logic    rst,
  ncs_item_if.sink     items,    // load and point words
  ncs_result_if.source results,  // nearest index and distance words
  ncs_cfg_if.sink      cfg       // register writes
);

  // command and status between sequencer and datapath
  ncs_cmd_t  cmd;
  ncs_stat_t stat;

  // state machine: idle / walk / drain
  ncs_ctrl u_ctrl (
    .clk  (clk),
    .rst  (rst),
    .stat (stat),
    .cmd  (cmd)
  );

  // tables, counters, distance pipeline and output register
  ncs_dp u_dp (
    .clk     (clk),
    .rst     (rst),
    .items   (items),
    .results (results),
    .cfg     (cfg),
    .cmd     (cmd),
    .stat    (stat)
  );

endmodule

`default_nettype wire

// ----- tb/sv/tb_top.sv -----
// self-checking testbench for the nearest centroid search block
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import ncs_pkg::*;

  // one input word as the testbench sees it
  typedef struct {
    logic                         action;
    logic [IDX_W-1:0]             centroid;
    logic [IDX_W-1:0]             dim;
    logic signed [COORD_BITS-1:0] coord;
  } in_word_t;

  // one expected result word
  typedef struct {
    logic [IDX_W-1:0]  index;
    logic [DIST_W-1:0] distance;
  } match_t;

  // how random coordinates are spread
  typedef enum int {SPREAD_FULL, SPREAD_TINY, SPREAD_EDGE, SPREAD_MID} spread_t;

  localparam logic [REG_IDX_W-1:0] REG_UNMAPPED  = REG_IDX_W'(2);
  localparam logic [REG_IDX_W-1:0] REG_TOP_INDEX = '1;

  localparam logic signed [COORD_BITS-1:0] COORD_MAX = 16'sh7fff;
  localparam logic signed [COORD_BITS-1:0] COORD_MIN = 16'sh8000;

  localparam longint unsigned DIST_CEIL = (64'd1 << DIST_W) - 64'd1;

  // stimulus sizing
  localparam int WORD_TARGET  = 1250;  // words that reach the block's state
  localparam int IDLE_STOP    = 1030;  // no idling beyond this many words
  localparam int PHASE_WORDS  = 110;   // words per register setting
  localparam int QUIET_CYCLES = 16;    // settle time once the channels are quiet, this is plenty
  localparam int TAIL_CYCLES  = 150;   // longer than the longest walk in use

  // register settings walked through by the random part, raw values
  // (zero and values above 64 included on purpose)
  localparam int STEPS = 12;
  localparam int CLUSTER_STEPS [STEPS] = '{4, 127, 2, 1, 8, 65, 6, 3, 16, 0, 64, 5};
  localparam int DIM_STEPS     [STEPS] = '{3, 1, 64, 8, 4, 2, 6, 16, 2, 127, 1, 5};

  logic clk = 1'b0;
  logic rst = 1'b1;

  always #4 clk = ~clk;

  ncs_item_if   items_if ();
  ncs_result_if results_if ();
  ncs_cfg_if    cfg_if ();

  nearest_centroid_search_top DUT (
    .clk     (clk),
    .rst     (rst),
    .items   (items_if),
    .results (results_if),
    .cfg     (cfg_if)
  );

  // everything the testbench drives starts at a known value
  logic                         src_valid    = 1'b0;
  logic                         src_action   = ACT_LOAD;
  logic [IDX_W-1:0]             src_centroid = '0;
  logic [IDX_W-1:0]             src_dim      = '0;
  logic signed [COORD_BITS-1:0] src_coord    = '0;
  logic                         snk_ready    = 1'b0;
  logic                         reg_valid    = 1'b0;
  logic [REG_IDX_W-1:0]         reg_index    = '0;
  logic [CFG_W-1:0]             reg_data     = '0;

  assign items_if.valid          = src_valid;
  assign items_if.action         = src_action;
  assign items_if.centroid_index = src_centroid;
  assign items_if.dim_index      = src_dim;
  assign items_if.coord_value    = src_coord;
  assign results_if.ready        = snk_ready;
  assign cfg_if.valid            = reg_valid;
  assign cfg_if.index            = reg_index;
  assign cfg_if.data             = reg_data;

  // predictor state: table, point buffer and the two counts in effect
  logic signed [COORD_BITS-1:0] centroid_coords [MAX_CENTROIDS][MAX_DIMS];
  logic signed [COORD_BITS-1:0] point_coords [MAX_DIMS];
  int n_clusters = 1;
  int n_dims     = 1;

  // generator's record of which entries hold a value, so no search ever
  // reads an entry that was never written
  bit cent_loaded [MAX_CENTROIDS][MAX_DIMS];
  bit point_loaded [MAX_DIMS];

  in_word_t word_backlog [$];  // words waiting for the driver
  match_t   nearest_due [$];   // results the block still owes

  int useful_words = 0;
  int errors       = 0;
  bit src_idle_en  = 1'b1;
  bit snk_idle_en  = 1'b1;
  int src_gap      = 0;
  int snk_stall    = 0;

  task automatic report_mismatch(input string msg);
    $display("%0t: mismatch: %s", $time, msg);
    errors++;
  endtask

  // zero counts as one, anything above the table size saturates
  function automatic int clamp_count(input logic [CFG_W-1:0] raw, input int top);
    if (raw == '0) return 1;
    return (int'(raw) > top) ? top : int'(raw);
  endfunction

  // apply one accepted word; a word that ends a point queues the nearest
  // centroid (lowest index on ties) and its squared distance
  function automatic void search_nearest(input in_word_t w);
    longint unsigned best_dist;
    longint unsigned sum;
    longint unsigned sq;
    longint          diff;
    int              best_c;
    if (int'(w.dim) >= n_dims) return;
    if (w.action == ACT_LOAD) begin
      if (int'(w.centroid) < n_clusters) centroid_coords[w.centroid][w.dim] = w.coord;
      return;
    end
    point_coords[w.dim] = w.coord;
    if (int'(w.dim) != n_dims - 1) return;
    best_dist = 0;
    best_c    = 0;
    for (int c = 0; c < n_clusters; c++) begin
      sum = 0;
      for (int d = 0; d < n_dims; d++) begin
        diff = longint'(point_coords[d]) - longint'(centroid_coords[c][d]);
        sq   = diff * diff;
        sum  = (sq > DIST_CEIL - sum) ? DIST_CEIL : sum + sq;
      end
      if (c == 0 || sum < best_dist) begin
        best_dist = sum;
        best_c    = c;
      end
    end
    nearest_due = {nearest_due,
                   match_t'{index: IDX_W'(best_c), distance: DIST_W'(best_dist)}};
  endfunction

  // queue a word and note what it writes under the counts now in effect
  function automatic void push_word(input logic act, input int c, input int d,
                                    input logic signed [COORD_BITS-1:0] v);
    word_backlog = {word_backlog, in_word_t'{act, IDX_W'(c), IDX_W'(d), v}};
    if (d >= n_dims || (act == ACT_LOAD && c >= n_clusters)) return;
    if (act == ACT_LOAD) cent_loaded[c][d] = 1'b1;
    else point_loaded[d] = 1'b1;
    useful_words++;
  endfunction

  function automatic logic signed [COORD_BITS-1:0] rand_coord(input spread_t spread);
    case (spread)
      SPREAD_FULL: return COORD_BITS'($urandom());
      SPREAD_TINY: return COORD_BITS'(int'($urandom_range(0, 4)) - 2);
      SPREAD_EDGE: begin
        case ($urandom_range(0, 3))
          0: return COORD_MIN;
          1: return COORD_MAX;
          2: return '0;
          default: return '1;
        endcase
      end
      default: return COORD_BITS'(int'($urandom_range(0, 2000)) - 1000);
    endcase
  endfunction

  // register write; only called while the block is idle
  task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [CFG_W-1:0] value);
    @(posedge clk);
    reg_valid <= 1'b1;
    reg_index <= idx;
    reg_data  <= value;
    do @(posedge clk); while (!cfg_if.ready);
    reg_valid <= 1'b0;
    if (idx == REG_CLUSTERS) n_clusters = clamp_count(value, MAX_CENTROIDS);
    else if (idx == REG_DIMS) n_dims = clamp_count(value, MAX_DIMS);
  endtask

  // wait for every queued word to go in and every owed result to come out,
  // then let the block settle; checked on the falling edge so the driver's
  // updates of this cycle are already visible
  task automatic wait_idle(input int settle);
    do @(negedge clk); while (word_backlog.size() != 0 || src_valid || nearest_due.size() != 0);
    repeat (settle) @(posedge clk);
  endtask

  // driver: presents backlog words, holds a word until it is taken,
  // and inserts idle bursts between words
  always @(posedge clk) begin
    in_word_t w;
    logic     fire;
    if (rst) begin
      src_valid <= 1'b0;
    end else begin
      fire = src_valid && items_if.ready;
      if (fire) begin
        w = '{src_action, src_centroid, src_dim, src_coord};
        search_nearest(w);
        if (src_idle_en && $urandom_range(0, 5) == 0) src_gap = $urandom_range(1, 7);
      end
      if (src_valid && !fire) begin
        // word still waiting, keep it on the bus
      end else if (src_gap != 0) begin
        src_gap--;
        src_valid <= 1'b0;
      end else if (word_backlog.size() != 0) begin
        w = word_backlog.pop_front();
        src_valid    <= 1'b1;
        src_action   <= w.action;
        src_centroid <= w.centroid;
        src_dim      <= w.dim;
        src_coord    <= w.coord;
      end else begin
        src_valid <= 1'b0;
      end
    end
  end

  // monitor: checks each result word against the oldest owed result and
  // stalls the result channel in bursts
  always @(posedge clk) begin
    match_t due;
    if (rst) begin
      snk_ready <= 1'b0;
    end else begin
      if (results_if.valid && snk_ready) begin
        if (nearest_due.size() == 0) begin
          report_mismatch($sformatf("result word index %0d distance %0d with nothing owed",
                                    results_if.nearest_index, results_if.squared_distance));
        end else begin
          due = nearest_due.pop_front();
          if (results_if.nearest_index !== due.index)
            report_mismatch($sformatf("nearest_index %0d, expected %0d",
                                      results_if.nearest_index, due.index));
          if (results_if.squared_distance !== due.distance)
            report_mismatch($sformatf("squared_distance %0d, expected %0d",
                                      results_if.squared_distance, due.distance));
        end
      end
      if (snk_stall != 0) begin
        snk_stall--;
        snk_ready <= 1'b0;
      end else if (snk_idle_en && $urandom_range(0, 4) == 0) begin
        snk_stall = $urandom_range(0, 6);
        snk_ready <= 1'b0;
      end else begin
        snk_ready <= 1'b1;
      end
    end
  end

  // stimulus and end of run
  initial begin
    int      phase;
    int      phase_start;
    int      c_pick;
    int      d_pick;
    logic    act;
    bit      refresh;
    spread_t spread;

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // directed part: three centroids of two dimensions
    write_reg(REG_CLUSTERS, CFG_W'(3));
    write_reg(REG_DIMS, CFG_W'(2));
    // centroid 0 at the origin, 1 at the top corner, 2 at the bottom corner
    push_word(ACT_LOAD, 0, 0, '0);
    push_word(ACT_LOAD, 0, 1, '0);
    push_word(ACT_LOAD, 1, 0, COORD_MAX);
    push_word(ACT_LOAD, 1, 1, COORD_MAX);
    push_word(ACT_LOAD, 2, 0, COORD_MIN);
    push_word(ACT_LOAD, 2, 1, COORD_MIN);
    // point on centroid 2: zero distance at a nonzero index
    push_word(ACT_POINT, 0, 0, COORD_MIN);
    push_word(ACT_POINT, 63, 1, COORD_MIN);
    // opposite corners: largest differences of the coordinate range
    push_word(ACT_POINT, 0, 0, COORD_MAX);
    push_word(ACT_POINT, 0, 1, COORD_MIN);
    // only the last coordinate rewritten: centroids 0 and 1 tie
    push_word(ACT_POINT, 0, 1, '0);
    // move centroid 1 to (2,2); point (1,1) ties centroids 0 and 1
    push_word(ACT_LOAD, 1, 0, 16'sd2);
    push_word(ACT_LOAD, 1, 1, 16'sd2);
    push_word(ACT_POINT, 0, 0, 16'sd1);
    push_word(ACT_POINT, 0, 1, 16'sd1);
    // out of range words: centroid beyond the count, dimension beyond the count
    push_word(ACT_LOAD, 3, 0, COORD_MAX);
    push_word(ACT_LOAD, 63, 0, COORD_MAX);
    push_word(ACT_LOAD, 0, 2, COORD_MAX);
    push_word(ACT_POINT, 0, 2, COORD_MAX);
    push_word(ACT_POINT, 0, 63, COORD_MIN);
    // a point coordinate that does not end the point, then the one that does
    push_word(ACT_POINT, 0, 0, '1);
    push_word(ACT_POINT, 0, 1, COORD_MIN);
    wait_idle(QUIET_CYCLES);

    // zero counts act as one; writes to unmapped indexes change nothing
    write_reg(REG_CLUSTERS, '0);
    write_reg(REG_DIMS, '0);
    write_reg(REG_UNMAPPED, CFG_W'(5));
    write_reg(REG_TOP_INDEX, '1);
    push_word(ACT_POINT, 0, 0, COORD_MIN);
    push_word(ACT_POINT, 0, 1, COORD_MAX);
    wait_idle(QUIET_CYCLES);

    // random part: one register setting per phase; source idling is off for every
    // fourth phase, sink idling for another fourth, and both for the last stretch
    phase = 0;
    while (useful_words < WORD_TARGET) begin
      wait_idle(QUIET_CYCLES);
      src_idle_en = (useful_words < IDLE_STOP) && (phase % 4 != 3);
      snk_idle_en = (useful_words < IDLE_STOP) && (phase % 4 != 1);
      write_reg(REG_CLUSTERS, CFG_W'(CLUSTER_STEPS[phase % STEPS]));
      write_reg(REG_DIMS, CFG_W'(DIM_STEPS[phase % STEPS]));
      phase_start = useful_words;
      while (useful_words - phase_start < PHASE_WORDS) begin
        spread = spread_t'($urandom_range(0, 3));
        // every centroid coordinate in use gets a value before the search;
        // small tables are sometimes reloaded whole, which makes ties likely
        refresh = (n_clusters * n_dims <= 32) && ($urandom_range(0, 3) == 0);
        for (int c = 0; c < n_clusters; c++)
          for (int d = 0; d < n_dims; d++)
            if (!cent_loaded[c][d] || refresh) push_word(ACT_LOAD, c, d, rand_coord(spread));
        repeat ($urandom_range(0, 3))
          push_word(ACT_LOAD, $urandom_range(0, n_clusters - 1), $urandom_range(0, n_dims - 1),
                    rand_coord(spread));
        // point coordinates; some already loaded ones are kept
        for (int d = 0; d < n_dims - 1; d++)
          if (!point_loaded[d] || $urandom_range(0, 1) == 0)
            push_word(ACT_POINT, $urandom_range(0, 63), d, rand_coord(spread));
        // most sequences end the point, a few are cut short
        if ($urandom_range(0, 7) != 0)
          push_word(ACT_POINT, $urandom_range(0, 63), n_dims - 1, rand_coord(spread));
        // stray words over the whole index range; everything in use holds a
        // value by now, so even one that ends a point is safe
        repeat ($urandom_range(0, 2)) begin
          act    = 1'($urandom_range(0, 1));
          c_pick = $urandom_range(0, 63);
          d_pick = $urandom_range(0, 63);
          push_word(act, c_pick, d_pick, rand_coord(spread_t'($urandom_range(0, 3))));
        end
      end
      phase++;
    end

    src_idle_en = 1'b0;
    snk_idle_en = 1'b0;
    wait_idle(TAIL_CYCLES);
    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // watchdog, several times the slowest correct run
  initial begin
    #(8_000_000);
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
